@@ src/lpc_pkg.sv @@
// shared types and constants for the led pattern controller
`default_nettype none

package lpc_pkg;

    localparam int CNT_W      = 16;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 2;
    localparam int OUT_W      = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int STEP_W     = $clog2(CNT_W);
    localparam int SUB_W      = 2 * CNT_W;

    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(CNT_W - 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = '0;

    // led modes; the two top codes are stored but behave like a free-running counter
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHORT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LONG  = 3'd5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SLOW_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAST_PERIOD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_FLASH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_FLASH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INVERT      = 3'd4;

    localparam logic [CNT_W-1:0] RST_SLOW_PERIOD = 16'd1000;
    localparam logic [CNT_W-1:0] RST_FAST_PERIOD = 16'd200;
    localparam logic [CNT_W-1:0] RST_SHORT_FLASH = 16'd100;
    localparam logic [CNT_W-1:0] RST_LONG_FLASH  = 16'd500;
    localparam logic [OUT_W-1:0] RST_INVERT      = 4'd0;

    typedef struct packed {
        logic [CNT_W-1:0] slow_period;
        logic [CNT_W-1:0] fast_period;
        logic [CNT_W-1:0] short_flash;
        logic [CNT_W-1:0] long_flash;
        logic [OUT_W-1:0] invert_mask;
    } t_cfg;

    typedef struct packed {
        logic wr;         // any register write this cycle
        logic period_wr;  // write to a blink period register
    } t_reg_evt;

    typedef struct packed {
        logic              tick;
        logic              set;
        logic [MODE_W-1:0] mode;
        logic              rem_load;
        logic              rem_step;
        logic [STEP_W-1:0] rem_shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ src/lpc_if.sv @@
// request channel interfaces for command input and pattern result
`default_nettype none

interface lpc_in_if;
    import lpc_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IDX_W-1:0]  led_index;
    logic [MODE_W-1:0] mode;

    modport source (output valid, output cmd, output led_index, output mode, input ready);
    modport sink (input valid, input cmd, input led_index, input mode, output ready);
endinterface

interface lpc_out_if;
    import lpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] lit_mask;

    modport source (output valid, output pin_levels, output lit_mask, input ready);
    modport sink (input valid, input pin_levels, input lit_mask, output ready);
endinterface

`default_nettype wire

@@ src/lpc_apb_regs.sv @@
// apb configuration registers of the led pattern controller
`default_nettype none

module lpc_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output lpc_pkg::t_cfg                       o_cfg,
    output lpc_pkg::t_reg_evt                   o_evt
);
    import lpc_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_SLOW_PERIOD: n_cfg.slow_period = pwdata[CNT_W-1:0];
                REG_FAST_PERIOD: n_cfg.fast_period = pwdata[CNT_W-1:0];
                REG_SHORT_FLASH: n_cfg.short_flash = pwdata[CNT_W-1:0];
                REG_LONG_FLASH:  n_cfg.long_flash  = pwdata[CNT_W-1:0];
                REG_INVERT:      n_cfg.invert_mask = pwdata[OUT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_period <= RST_SLOW_PERIOD;
            r_cfg.fast_period <= RST_FAST_PERIOD;
            r_cfg.short_flash <= RST_SHORT_FLASH;
            r_cfg.long_flash  <= RST_LONG_FLASH;
            r_cfg.invert_mask <= RST_INVERT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SLOW_PERIOD: prdata = APB_DATA_W'(r_cfg.slow_period);
            REG_FAST_PERIOD: prdata = APB_DATA_W'(r_cfg.fast_period);
            REG_SHORT_FLASH: prdata = APB_DATA_W'(r_cfg.short_flash);
            REG_LONG_FLASH:  prdata = APB_DATA_W'(r_cfg.long_flash);
            REG_INVERT:      prdata = APB_DATA_W'(r_cfg.invert_mask);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg           = r_cfg;
    assign o_evt.wr        = w_wr;
    assign o_evt.period_wr = w_wr && (w_idx == REG_SLOW_PERIOD || w_idx == REG_FAST_PERIOD);

endmodule

`default_nettype wire

@@ src/lpc_led_cell.sv @@
// state and update logic of one led: mode, light, counter and period remainder
`default_nettype none

module lpc_led_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpc_pkg::t_cell_ctl i_ctl,
    input  wire lpc_pkg::t_cfg      i_cfg,
    output logic                    o_lit_next
);
    import lpc_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;
    logic              r_lit;
    logic              n_lit;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  n_rem;

    logic [CNT_W-1:0]  w_slow_p;
    logic [CNT_W-1:0]  w_fast_p;
    logic [CNT_W-1:0]  w_period;
    logic [CNT_W-1:0]  w_inc;
    logic [CNT_W-1:0]  w_rem_inc;
    logic [CNT_W:0]    w_twice;
    logic [CNT_W:0]    w_per_ext;
    logic [SUB_W-1:0]  w_sub;
    logic [CNT_W-1:0]  w_rem_next;

    // zero period behaves as one
    assign w_slow_p  = (i_cfg.slow_period == '0) ? CNT_W'(1) : i_cfg.slow_period;
    assign w_fast_p  = (i_cfg.fast_period == '0) ? CNT_W'(1) : i_cfg.fast_period;
    assign w_period  = (r_mode == MODE_FAST) ? w_fast_p : w_slow_p;
    assign w_inc     = r_count + CNT_W'(1);
    // blinking leds take their phase from the remainder; the raw counter stays for
    // a later period change
    assign w_rem_inc = r_rem + CNT_W'(1);
    assign w_twice   = {r_rem, 1'b0};
    assign w_per_ext = {1'b0, w_period};

    // one restoring step of count mod period, shifted divisor from the top bit down
    assign w_sub      = SUB_W'(w_period) << i_ctl.rem_shift;
    assign w_rem_next = (SUB_W'(r_rem) >= w_sub) ? (r_rem - w_sub[CNT_W-1:0]) : r_rem;

    always_comb begin
        n_mode  = r_mode;
        n_lit   = r_lit;
        n_count = r_count;
        n_rem   = r_rem;

        if (i_ctl.rem_load) begin
            n_rem = r_count;
        end else if (i_ctl.rem_step) begin
            n_rem = w_rem_next;
        end

        if (i_ctl.set) begin
            n_mode  = i_ctl.mode;
            n_count = '0;
            n_rem   = '0;
            unique case (i_ctl.mode)
                MODE_OFF: begin
                    n_lit = 1'b0;
                end
                MODE_ON: begin
                    n_lit = 1'b1;
                end
                MODE_SHORT: begin
                    n_count = i_cfg.short_flash;
                    n_lit   = 1'b1;
                end
                MODE_LONG: begin
                    n_count = i_cfg.long_flash;
                    n_lit   = 1'b1;
                end
                default: begin
                    n_lit = r_lit;
                end
            endcase
        end else if (i_ctl.tick) begin
            unique case (r_mode)
                MODE_SLOW, MODE_FAST: begin
                    // remainder is always kept below the period
                    if (w_twice > w_per_ext) begin
                        n_lit = 1'b0;
                    end else if (w_twice < w_per_ext) begin
                        n_lit = 1'b1;
                    end
                    n_count = (w_rem_inc == w_period) ? '0 : w_rem_inc;
                    n_rem   = n_count;
                end
                MODE_SHORT, MODE_LONG: begin
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_mode  = MODE_OFF;
                        n_lit   = 1'b0;
                        n_count = '0;
                    end
                end
                default: begin
                    n_count = w_inc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_lit   <= 1'b0;
            r_count <= '0;
            r_rem   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_lit   <= n_lit;
            r_count <= n_count;
            r_rem   <= n_rem;
        end
    end

    assign o_lit_next = n_lit;

endmodule

`default_nettype wire

@@ src/led_pattern_controller.sv @@
// led pattern controller: per-led blink and flash patterns with apb configuration
// a request's result is captured in the output register at the edge that accepts it;
// one request per cycle when the result side keeps up and no register write or remainder pass holds it off.
// a write to either blink period blocks requests in the write cycle and during a
// 16-step remainder pass that reduces every blinking counter modulo its new period.
// synchronous active-low reset: all leds off and dark, counters zero, registers at defaults.
`default_nettype none

module led_pattern_controller #(
    parameter int NUM_LEDS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lpc_in_if.sink                              i_in,
    lpc_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import lpc_pkg::*;

    t_cfg              w_cfg;
    t_reg_evt          w_evt;
    logic              w_accept;
    logic              w_in_ready;
    logic [NUM_LEDS-1:0] w_lit_next;
    logic [OUT_W-1:0]  w_lit_out;

    logic              r_rem_active;
    logic              n_rem_active;
    logic [STEP_W-1:0] r_rem_shift;
    logic [STEP_W-1:0] n_rem_shift;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_pin_levels;
    logic [OUT_W-1:0]  r_lit_mask;

    lpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_evt   (w_evt)
    );

    assign w_in_ready = (!r_out_valid || o_out.ready) && !r_rem_active && !w_evt.wr;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // remainder pass sequencing
    always_comb begin
        n_rem_active = r_rem_active;
        n_rem_shift  = r_rem_shift;
        if (w_evt.period_wr) begin
            n_rem_active = 1'b1;
            n_rem_shift  = STEP_FIRST;
        end else if (r_rem_active) begin
            if (r_rem_shift == STEP_LAST) begin
                n_rem_active = 1'b0;
            end else begin
                n_rem_shift = r_rem_shift - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_active <= 1'b0;
            r_rem_shift  <= STEP_FIRST;
        end else begin
            r_rem_active <= n_rem_active;
            r_rem_shift  <= n_rem_shift;
        end
    end

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
        t_cell_ctl w_ctl;

        always_comb begin
            w_ctl.tick      = w_accept && (i_in.cmd == CMD_TICK);
            w_ctl.set       = w_accept && (i_in.cmd == CMD_SET) && (32'(i_in.led_index) == g);
            w_ctl.mode      = i_in.mode;
            w_ctl.rem_load  = w_evt.period_wr;
            w_ctl.rem_step  = r_rem_active && !w_evt.period_wr;
            w_ctl.rem_shift = r_rem_shift;
        end

        lpc_led_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cfg      (w_cfg),
            .o_lit_next (w_lit_next[g])
        );
    end

    for (genvar b = 0; b < OUT_W; b++) begin : g_out
        if (b < NUM_LEDS) begin : g_used
            assign w_lit_out[b] = w_lit_next[b];
        end else begin : g_unused
            assign w_lit_out[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lit_mask   <= w_lit_out;
            r_pin_levels <= w_lit_out ^ w_cfg.invert_mask;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.lit_mask   = r_lit_mask;
    assign o_out.pin_levels = r_pin_levels;

endmodule

`default_nettype wire

@@ src/lpc_checker.sv @@
// port-level checks of the led pattern controller and their binding
`default_nettype none

module lpc_checker #(
    parameter int NUM_LEDS = 4
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_in_cmd,
    input wire logic [lpc_pkg::IDX_W-1:0]      i_in_led_index,
    input wire logic [lpc_pkg::MODE_W-1:0]     i_in_mode,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [lpc_pkg::OUT_W-1:0]      i_out_pin_levels,
    input wire logic [lpc_pkg::OUT_W-1:0]      i_out_lit_mask,
    input wire logic                           i_psel,
    input wire logic                           i_penable,
    input wire logic                           i_pwrite,
    input wire logic [lpc_pkg::APB_ADDR_W-1:0] i_paddr
);
    import lpc_pkg::*;

    logic w_period_wr;
    logic w_set_on;

    assign w_period_wr = i_psel && i_penable && i_pwrite &&
                         (i_paddr[APB_ADDR_W-1:2] == REG_SLOW_PERIOD ||
                          i_paddr[APB_ADDR_W-1:2] == REG_FAST_PERIOD);
    assign w_set_on    = i_in_valid && i_in_ready && (i_in_cmd == CMD_SET) &&
                         (i_in_mode == MODE_ON) && (32'(i_in_led_index) < NUM_LEDS);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_lit_mask) && $stable(i_out_pin_levels))
        else $error("result payload changed while stalled");

    // new period starts the remainder pass, which blocks requests
    a_period_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_period_wr |=> !i_in_ready)
        else $error("request taken during remainder pass");

    // switching an led on shows up lit in the very next result
    a_on_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_set_on |=> i_out_valid && i_out_lit_mask[$past(i_in_led_index)])
        else $error("led not lit after on request");

endmodule

bind led_pattern_controller lpc_checker #(.NUM_LEDS(NUM_LEDS)) u_lpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_cmd         (i_in.cmd),
    .i_in_led_index   (i_in.led_index),
    .i_in_mode        (i_in.mode),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_pin_levels (o_out.pin_levels),
    .i_out_lit_mask   (o_out.lit_mask),
    .i_psel           (psel),
    .i_penable        (penable),
    .i_pwrite         (pwrite),
    .i_paddr          (paddr)
);

`default_nettype wire

@@ tb/sv/lpc_light_check.sv @@
// led pattern predictor and result comparison for the led pattern controller bench
`timescale 1ns / 1ps

module lpc_light_check #(
    parameter int NUM_LEDS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lpc_in_if                                i_cmd_bus,
    lpc_out_if                               i_res_bus,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [lpc_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [lpc_pkg::APB_DATA_W-1:0]   i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lpc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] pin_levels;
        logic [OUT_W-1:0] lit_mask;
    } t_lights;

    t_lights           lights_q [$];
    t_cfg              cfg;
    logic [MODE_W-1:0] shadow_mode [NUM_LEDS];
    logic              shadow_lit  [NUM_LEDS];
    logic [CNT_W-1:0]  shadow_cnt  [NUM_LEDS];
    int                fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void load_mode(input int n, input logic [MODE_W-1:0] m);
        shadow_mode[n] = m;
        shadow_cnt[n]  = '0;
        case (m)
            MODE_OFF: shadow_lit[n] = 1'b0;
            MODE_ON:  shadow_lit[n] = 1'b1;
            MODE_SHORT: begin
                shadow_cnt[n] = cfg.short_flash;
                shadow_lit[n] = 1'b1;
            end
            MODE_LONG: begin
                shadow_cnt[n] = cfg.long_flash;
                shadow_lit[n] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // light follows the half of the period the counter sits in; exact middle keeps it
    function automatic void blink_step(input int n, input logic [CNT_W-1:0] period);
        int unsigned p;
        int unsigned c;
        p = (period == '0) ? 1 : int'(period);
        c = int'(shadow_cnt[n]) % p;
        if (2 * c > p)
            shadow_lit[n] = 1'b0;
        else if (2 * c < p)
            shadow_lit[n] = 1'b1;
        shadow_cnt[n] = CNT_W'((c + 1) % p);
    endfunction

    function automatic void tick_bank();
        int n;
        for (n = 0; n < NUM_LEDS; n++) begin
            case (shadow_mode[n])
                MODE_SLOW: blink_step(n, cfg.slow_period);
                MODE_FAST: blink_step(n, cfg.fast_period);
                MODE_SHORT, MODE_LONG: begin
                    if (shadow_cnt[n] != '0)
                        shadow_cnt[n] = shadow_cnt[n] - 1'b1;
                    else
                        load_mode(n, MODE_OFF);
                end
                default: shadow_cnt[n] = shadow_cnt[n] + 1'b1;
            endcase
        end
    endfunction

    function automatic t_lights predict_lights(input logic c, input logic [IDX_W-1:0] idx,
                                               input logic [MODE_W-1:0] m);
        t_lights r;
        int      n;
        if (c == CMD_SET) begin
            if (int'(idx) < NUM_LEDS)
                load_mode(int'(idx), m);
        end else begin
            tick_bank();
        end
        r.lit_mask = '0;
        for (n = 0; n < NUM_LEDS && n < OUT_W; n++)
            r.lit_mask[n] = shadow_lit[n];
        r.pin_levels = r.lit_mask ^ cfg.invert_mask;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_bus
        t_lights want;
        int      n;
        if (!i_rst_n) begin
            cfg.slow_period = RST_SLOW_PERIOD;
            cfg.fast_period = RST_FAST_PERIOD;
            cfg.short_flash = RST_SHORT_FLASH;
            cfg.long_flash  = RST_LONG_FLASH;
            cfg.invert_mask = RST_INVERT;
            for (n = 0; n < NUM_LEDS; n++) begin
                shadow_mode[n] = MODE_OFF;
                shadow_lit[n]  = 1'b0;
                shadow_cnt[n]  = '0;
            end
            lights_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    REG_SLOW_PERIOD: cfg.slow_period = i_pwdata[CNT_W-1:0];
                    REG_FAST_PERIOD: cfg.fast_period = i_pwdata[CNT_W-1:0];
                    REG_SHORT_FLASH: cfg.short_flash = i_pwdata[CNT_W-1:0];
                    REG_LONG_FLASH:  cfg.long_flash  = i_pwdata[CNT_W-1:0];
                    REG_INVERT:      cfg.invert_mask = i_pwdata[OUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd_bus.valid && i_cmd_bus.ready)
                lights_q.push_back(predict_lights(i_cmd_bus.cmd, i_cmd_bus.led_index,
                                                  i_cmd_bus.mode));
            if (i_res_bus.valid && i_res_bus.ready) begin
                if (lights_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fails++;
                end else begin
                    want = lights_q.pop_front();
                    if (i_res_bus.pin_levels !== want.pin_levels) begin
                        $error("pin_levels: expected %h, got %h",
                               want.pin_levels, i_res_bus.pin_levels);
                        fails++;
                    end
                    if (i_res_bus.lit_mask !== want.lit_mask) begin
                        $error("lit_mask: expected %h, got %h",
                               want.lit_mask, i_res_bus.lit_mask);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= lights_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// top of the led pattern controller bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import lpc_pkg::*;

    localparam int N_LEDS      = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_ITEMS  = 1650;
    localparam int SEGMENTS    = 6;
    localparam int END_WAIT    = 20;

    // spare mode codes: stored by the block, no pattern of their own
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_count;
    int   pending_cnt;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    logic hold_req      = 1'b0;

    lpc_in_if  cmd_if ();
    lpc_out_if res_if ();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_pattern_controller #(
        .NUM_LEDS (N_LEDS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lpc_light_check #(
        .NUM_LEDS (N_LEDS)
    ) u_light_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_bus    (cmd_if),
        .i_res_bus    (res_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // result side: random back-pressure, plus one long hold-off each time hold_req is raised
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_left = LONG_HOLD - 1;
                hold_req <= 1'b0;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_cfg make_setting(input logic [CNT_W-1:0] slow_p,
                                          input logic [CNT_W-1:0] fast_p,
                                          input logic [CNT_W-1:0] short_n,
                                          input logic [CNT_W-1:0] long_n,
                                          input logic [OUT_W-1:0] inv);
        t_cfg s;
        s.slow_period = slow_p;
        s.fast_period = fast_p;
        s.short_flash = short_n;
        s.long_flash  = long_n;
        s.invert_mask = inv;
        return s;
    endfunction

    function automatic t_cfg pick_setting(input int seg);
        case (seg)
            0: return make_setting(16'd1, 16'd0, 16'hFFFF, 16'd0, 4'hF);
            1: return make_setting(16'hFFFF, 16'd2, 16'd3, 16'd1, 4'h0);
            2: return make_setting(16'd5, 16'd4, 16'd2, 16'd9, 4'hA);
            default: return make_setting(CNT_W'($urandom_range(12)),
                                         CNT_W'($urandom_range(12)),
                                         CNT_W'($urandom_range(15)),
                                         CNT_W'($urandom_range(20)),
                                         OUT_W'($urandom_range(15)));
        endcase
    endfunction

    // setup cycle then access cycle; the bus is released by the caller
    task automatic apb_write(input logic [REG_IDX_W-1:0] r, input logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic write_config(input t_cfg s);
        apb_write(REG_SLOW_PERIOD, APB_DATA_W'(s.slow_period));
        apb_write(REG_FAST_PERIOD, APB_DATA_W'(s.fast_period));
        apb_write(REG_SHORT_FLASH, APB_DATA_W'(s.short_flash));
        apb_write(REG_LONG_FLASH, APB_DATA_W'(s.long_flash));
        apb_write(REG_INVERT, APB_DATA_W'(s.invert_mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_req(input logic c, input logic [IDX_W-1:0] idx,
                            input logic [MODE_W-1:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= c;
        cmd_if.led_index <= idx;
        cmd_if.mode      <= m;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // mostly ticks so patterns run through whole periods between mode changes
    task automatic send_random();
        logic [MODE_W-1:0] m;
        if ($urandom_range(99) < 75) begin
            send_req(CMD_TICK, IDX_W'($urandom), MODE_W'($urandom));
        end else begin
            if ($urandom_range(15) == 0)
                m = ($urandom_range(1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
            else
                m = MODE_W'($urandom_range(5));
            send_req(CMD_SET, IDX_W'($urandom), m);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
    endtask

    initial begin
        int seg;
        int k;
        rst_n            <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.cmd       <= CMD_TICK;
        cmd_if.led_index <= '0;
        cmd_if.mode      <= MODE_OFF;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // even and odd periods, zero length short flash, two tick long flash
        write_config(make_setting(16'd4, 16'd3, 16'd0, 16'd2, 4'b0101));
        send_req(CMD_TICK, 2'd3, MODE_SPARE7);
        send_req(CMD_SET, 2'd0, MODE_ON);
        send_req(CMD_SET, 2'd1, MODE_SLOW);
        send_req(CMD_SET, 2'd2, MODE_FAST);
        send_req(CMD_SET, 2'd3, MODE_SHORT);
        repeat (5) send_req(CMD_TICK, 2'd0, MODE_OFF);
        send_req(CMD_SET, 2'd3, MODE_LONG);
        repeat (4) send_req(CMD_TICK, 2'd1, MODE_ON);
        send_req(CMD_SET, 2'd0, MODE_SPARE6);
        send_req(CMD_SET, 2'd1, MODE_SPARE7);
        repeat (2) send_req(CMD_TICK, 2'd2, MODE_LONG);
        send_req(CMD_SET, 2'd2, MODE_OFF);
        send_req(CMD_SET, 2'd1, MODE_ON);
        cmd_if.valid <= 1'b0;
        wait_drained();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            send_idle_pct = (seg < 2) ? 36 : (seg < 4) ? 80 : 0;
            recv_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 36 : 0;
            write_config(pick_setting(seg));
            if (seg == 0 || seg == 4)
                hold_req <= 1'b1;
            for (k = 0; k < RAND_ITEMS / SEGMENTS; k++)
                send_random();
            cmd_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (END_WAIT) @(posedge clk);
        if (pending_cnt != 0)
            $error("%0d results never arrived", pending_cnt);
        if (fail_count == 0 && pending_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ led_pattern_controller.f @@
src/lpc_pkg.sv
src/lpc_if.sv
src/lpc_apb_regs.sv
src/lpc_led_cell.sv
src/led_pattern_controller.sv
src/lpc_checker.sv
tb/sv/lpc_light_check.sv
tb/sv/tb.sv
